### rtl/core/xcsd_pkg.sv
// ----------------------------------------------------------------------------
// xcsd_pkg
// Shared types and constants of the xor chunk sample decoder.
// ----------------------------------------------------------------------------
package xcsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // configuration register indexes
  localparam logic REG_COUNT_IN_HEADER = 1'b0;
  localparam logic REG_SAMPLE_TOTAL    = 1'b1;

  // timestamp that closes a series
  localparam logic [63:0] TIME_END = 64'h7fff_ffff_ffff_ffff;

  // delta-of-delta size codes
  localparam logic [1:0] DOD_64 = 2'd0;
  localparam logic [1:0] DOD_14 = 2'd1;
  localparam logic [1:0] DOD_17 = 2'd2;
  localparam logic [1:0] DOD_20 = 2'd3;

  // decode phases
  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_COUNT   = 12'b0000_0000_0010,
    PH_VARINT  = 12'b0000_0000_0100,
    PH_VAL64   = 12'b0000_0000_1000,
    PH_PREFIX  = 12'b0000_0001_0000,
    PH_DOD     = 12'b0000_0010_0000,
    PH_CTRL1   = 12'b0000_0100_0000,
    PH_CTRL2   = 12'b0000_1000_0000,
    PH_LEAD    = 12'b0001_0000_0000,
    PH_SIG     = 12'b0010_0000_0000,
    PH_MEANING = 12'b0100_0000_0000,
    PH_ADD     = 12'b1000_0000_0000
  } phase_t;

  // byte sequencing steps
  typedef enum logic [2:0] {
    ST_BITS = 3'b001,
    ST_ERR  = 3'b010,
    ST_OUT  = 3'b100
  } step_t;

  // one chunk byte
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  // one decoded result
  typedef struct packed {
    logic        last;
    logic [15:0] number;
    logic [63:0] value;
    logic [63:0] stamp;
    logic [1:0]  kind;
  } result_t;

endpackage

### rtl/core/xor_chunk_sample_decoder.sv
// ----------------------------------------------------------------------------
// xor_chunk_sample_decoder
// Delta-of-delta timestamp and xor value decoder for one compressed chunk.
// ----------------------------------------------------------------------------
// Chunk bytes enter through a two-entry request queue; the decoder takes a
// byte, walks it one bit per cycle while no result waits for the queue,
// spends an extra step on every timestamp advance (at most four in a byte)
// and then closes the byte before it takes the next one. Results leave
// through a second two-entry queue; each result is held until the next one
// appears or the byte is finished, so that the last result of a byte carries
// tlast. sample_total and count_in_header are sampled at the first bit of
// each chunk.
module xor_chunk_sample_decoder import xcsd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // stream_byte
  input  logic         s_axis_tlast,   // chunk_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // sample_time, sample_value_bits, sample_number
  output logic [1:0]   m_axis_tuser,   // result_kind
  output logic         m_axis_tlast    // run_last
);

  byte_item_t in_item;
  byte_item_t q_item;
  logic       q_valid;
  logic       q_ready;
  result_t    r_item;
  result_t    o_item;
  logic       r_valid;
  logic       r_ready;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // input request queue
  xcsd_fifo #(.W($bits(byte_item_t))) u_in_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_item)
  );

  // bit-serial decoder
  xcsd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_item  (r_item)
  );

  // result queue
  xcsd_fifo #(.W($bits(result_t))) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_data   (r_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (o_item)
  );

  assign m_axis_tdata = {o_item.number, o_item.value, o_item.stamp};
  assign m_axis_tuser = o_item.kind;
  assign m_axis_tlast = o_item.last;

endmodule

### rtl/core/xcsd_fifo.sv
// ----------------------------------------------------------------------------
// xcsd_fifo
// Two-entry request queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module xcsd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/xcsd_back.sv
// ----------------------------------------------------------------------------
// xcsd_back
// Bit-serial decoder: walks each byte one bit a cycle while not stalled, and forms results.
// ----------------------------------------------------------------------------
module xcsd_back import xcsd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  byte_item_t  in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_item
);

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // configuration
  logic          count_in_header;
  logic [15:0]   sample_total;

  // byte sequencing
  logic          busy;
  step_t         step;
  logic [3:0]    bit_cnt;
  byte_item_t    cur;

  // decode state
  phase_t        phase;
  logic [63:0]   accum;
  logic [6:0]    bits_left;
  logic [6:0]    vshift;
  logic [2:0]    ones;
  logic [63:0]   ltime;
  logic [63:0]   ldelta;
  logic [63:0]   lvalue;
  logic [4:0]    lead;
  logic [5:0]    trail;
  logic [CW-1:0] done_cnt;
  logic [CW-1:0] chunk_cnt;
  logic          stopped;
  logic [7:0]    vbyte;
  logic [1:0]    dcode;
  logic          held_v;
  result_t       held;

  phase_t        phase_next;
  logic [63:0]   accum_next;
  logic [6:0]    bits_left_next;
  logic [6:0]    vshift_next;
  logic [2:0]    ones_next;
  logic [63:0]   ltime_next;
  logic [63:0]   ldelta_next;
  logic [63:0]   lvalue_next;
  logic [4:0]    lead_next;
  logic [5:0]    trail_next;
  logic [CW-1:0] done_cnt_next;
  logic [CW-1:0] chunk_cnt_next;
  logic          stopped_next;
  logic [7:0]    vbyte_next;
  logic [1:0]    dcode_next;
  logic          busy_next;
  step_t         step_next;
  logic [3:0]    bit_cnt_next;
  logic          held_v_next;
  result_t       held_next;

  logic          emit_v;
  result_t       emit_r;
  logic          push;
  logic          stall;
  logic          take;
  logic          b;
  logic [63:0]   acc;
  logic [6:0]    bl;
  logic [7:0]    vb;
  logic [63:0]   vacc;
  logic [63:0]   z;
  logic [63:0]   dod;
  logic [63:0]   nv;
  logic [63:0]   tsum;
  logic [6:0]    sig7;
  logic [6:0]    lsum;
  logic [CW-1:0] done_inc;

  assign in_ready = !busy;
  assign take     = in_valid && !busy;

  // output side: a held result goes out once the next one appears or the byte ends
  assign push      = held_v && (emit_v || step == ST_OUT);
  assign out_valid = push;
  assign stall     = push && !out_ready;
  always_comb begin
    out_item      = held;
    out_item.last = (step == ST_OUT);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_in_header <= 1'b1;
      sample_total    <= 16'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_COUNT_IN_HEADER) begin
        count_in_header <= cfg_data[0];
      end else begin
        sample_total <= cfg_data;
      end
    end
  end

  // next-state logic of one step
  always_comb begin
    phase_next     = phase;
    accum_next     = accum;
    bits_left_next = bits_left;
    vshift_next    = vshift;
    ones_next      = ones;
    ltime_next     = ltime;
    ldelta_next    = ldelta;
    lvalue_next    = lvalue;
    lead_next      = lead;
    trail_next     = trail;
    done_cnt_next  = done_cnt;
    chunk_cnt_next = chunk_cnt;
    stopped_next   = stopped;
    vbyte_next     = vbyte;
    dcode_next     = dcode;
    busy_next      = busy;
    step_next      = step;
    bit_cnt_next   = bit_cnt;
    held_v_next    = held_v;
    held_next      = held;
    emit_v         = 1'b0;
    emit_r         = '0;
    emit_r.number  = done_cnt[15:0];

    b        = cur.data[3'd7 - bit_cnt[2:0]];
    acc      = {accum[62:0], b};
    bl       = bits_left - 7'd1;
    vb       = {vbyte[6:0], b};
    vacc     = accum | ({57'd0, vb[6:0]} << vshift[5:0]);
    z        = (vacc >> 1) ^ {64{vacc[0]}};
    nv       = lvalue ^ (acc << trail);
    tsum     = ltime + ldelta;
    sig7     = (acc[5:0] == 6'd0) ? 7'd64 : {1'b0, acc[5:0]};
    lsum     = {2'b00, lead} + sig7;
    done_inc = done_cnt + {{(CW-1){1'b0}}, 1'b1};

    // sign handling of the delta-of-delta field
    case (dcode)
      DOD_14: dod = (acc[13] && (acc[12:0] != 13'd0)) ? {{50{1'b1}}, acc[13:0]} : acc;
      DOD_17: dod = (acc[16] && (acc[15:0] != 16'd0)) ? {{47{1'b1}}, acc[16:0]} : acc;
      DOD_20: dod = (acc[19] && (acc[18:0] != 19'd0)) ? {{44{1'b1}}, acc[19:0]} : acc;
      default: dod = acc;
    endcase

    case (step)
      ST_BITS: begin
        if (phase == PH_ADD && !stopped) begin
          // time advance after a new delta
          ltime_next = tsum;
          if (tsum == TIME_END) begin
            emit_v       = 1'b1;
            emit_r.kind  = KIND_END;
            emit_r.stamp = tsum;
            stopped_next = 1'b1;
          end else begin
            phase_next = PH_CTRL1;
          end
        end else if (bit_cnt == 4'd8) begin
          step_next = ST_ERR;
        end else begin
          bit_cnt_next = bit_cnt + 4'd1;
          if (!stopped) begin
            case (phase)
              PH_IDLE: begin
                if (count_in_header) begin
                  phase_next     = PH_COUNT;
                  accum_next     = {63'd0, b};
                  bits_left_next = 7'(COUNT_BITS - 1);
                end else begin
                  chunk_cnt_next = CW'(sample_total);
                  if (sample_total == 16'd0) begin
                    stopped_next = 1'b1;
                  end else begin
                    phase_next     = PH_VARINT;
                    accum_next     = 64'd0;
                    vshift_next    = 7'd0;
                    vbyte_next     = {7'd0, b};
                    bits_left_next = 7'd7;
                  end
                end
              end
              PH_VARINT: begin
                vbyte_next     = vb;
                bits_left_next = bl;
                if (bl == 7'd0) begin
                  if (vshift >= 7'd63 && vb > 8'd1) begin
                    emit_v       = 1'b1;
                    emit_r.kind  = KIND_ERROR;
                    stopped_next = 1'b1;
                  end else begin
                    accum_next = vacc;
                    if (vb[7]) begin
                      vshift_next    = vshift + 7'd7;
                      vbyte_next     = 8'd0;
                      bits_left_next = 7'd8;
                    end else if (done_cnt == '0) begin
                      ltime_next     = z;
                      phase_next     = PH_VAL64;
                      accum_next     = 64'd0;
                      bits_left_next = 7'd64;
                    end else begin
                      ldelta_next = z;
                      phase_next  = PH_ADD;
                    end
                  end
                end
              end
              PH_PREFIX: begin
                if (b) begin
                  ones_next = ones + 3'd1;
                  if (ones == 3'd3) begin
                    dcode_next     = DOD_64;
                    phase_next     = PH_DOD;
                    accum_next     = 64'd0;
                    bits_left_next = 7'd64;
                  end
                end else if (ones == 3'd0) begin
                  phase_next = PH_ADD;
                end else begin
                  dcode_next     = ones[1:0];
                  phase_next     = PH_DOD;
                  accum_next     = 64'd0;
                  case (ones[1:0])
                    DOD_14:  bits_left_next = 7'd14;
                    DOD_17:  bits_left_next = 7'd17;
                    default: bits_left_next = 7'd20;
                  endcase
                end
              end
              PH_CTRL1: begin
                if (b) begin
                  phase_next = PH_CTRL2;
                end else begin
                  emit_v        = 1'b1;
                  emit_r.kind   = KIND_SAMPLE;
                  emit_r.stamp  = ltime;
                  emit_r.value  = lvalue;
                  done_cnt_next = done_inc;
                  if (done_inc == chunk_cnt) begin
                    stopped_next = 1'b1;
                  end else begin
                    phase_next = PH_PREFIX;
                    ones_next  = 3'd0;
                  end
                end
              end
              PH_CTRL2: begin
                accum_next = 64'd0;
                if (b) begin
                  phase_next     = PH_LEAD;
                  bits_left_next = 7'd5;
                end else begin
                  phase_next     = PH_MEANING;
                  bits_left_next = 7'd64 - {2'b00, lead} - {1'b0, trail};
                end
              end
              PH_COUNT, PH_VAL64, PH_DOD, PH_LEAD, PH_SIG, PH_MEANING: begin
                accum_next     = acc;
                bits_left_next = bl;
                if (bl == 7'd0) begin
                  case (phase)
                    PH_COUNT: begin
                      chunk_cnt_next = acc[CW-1:0];
                      if (acc[CW-1:0] == '0) begin
                        stopped_next = 1'b1;
                      end else begin
                        phase_next     = PH_VARINT;
                        accum_next     = 64'd0;
                        vshift_next    = 7'd0;
                        vbyte_next     = 8'd0;
                        bits_left_next = 7'd8;
                      end
                    end
                    PH_VAL64: begin
                      lvalue_next = acc;
                      emit_v      = 1'b1;
                      if (ltime == TIME_END) begin
                        emit_r.kind  = KIND_END;
                        emit_r.stamp = ltime;
                        stopped_next = 1'b1;
                      end else begin
                        emit_r.kind   = KIND_SAMPLE;
                        emit_r.stamp  = ltime;
                        emit_r.value  = acc;
                        done_cnt_next = {{(CW-1){1'b0}}, 1'b1};
                        if (chunk_cnt == {{(CW-1){1'b0}}, 1'b1}) begin
                          stopped_next = 1'b1;
                        end else begin
                          phase_next     = PH_VARINT;
                          accum_next     = 64'd0;
                          vshift_next    = 7'd0;
                          vbyte_next     = 8'd0;
                          bits_left_next = 7'd8;
                        end
                      end
                    end
                    PH_DOD: begin
                      ldelta_next = ldelta + dod;
                      phase_next  = PH_ADD;
                    end
                    PH_LEAD: begin
                      lead_next      = acc[4:0];
                      phase_next     = PH_SIG;
                      accum_next     = 64'd0;
                      bits_left_next = 7'd6;
                    end
                    PH_SIG: begin
                      if (lsum > 7'd64) begin
                        emit_v       = 1'b1;
                        emit_r.kind  = KIND_ERROR;
                        stopped_next = 1'b1;
                      end else begin
                        trail_next     = 6'(7'd64 - lsum);
                        phase_next     = PH_MEANING;
                        accum_next     = 64'd0;
                        bits_left_next = sig7;
                      end
                    end
                    default: begin
                      // xor-coded value complete
                      lvalue_next   = nv;
                      emit_v        = 1'b1;
                      emit_r.kind   = KIND_SAMPLE;
                      emit_r.stamp  = ltime;
                      emit_r.value  = nv;
                      done_cnt_next = done_inc;
                      if (done_inc == chunk_cnt) begin
                        stopped_next = 1'b1;
                      end else begin
                        phase_next = PH_PREFIX;
                        ones_next  = 3'd0;
                      end
                    end
                  endcase
                end
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
        end
      end
      ST_ERR: begin
        // chunk closed before the series did
        if (cur.last && !stopped) begin
          emit_v       = 1'b1;
          emit_r.kind  = KIND_ERROR;
          stopped_next = 1'b1;
        end
        step_next = ST_OUT;
      end
      default: begin
        held_v_next = 1'b0;
        busy_next   = 1'b0;
        if (cur.last) begin
          phase_next     = PH_IDLE;
          accum_next     = 64'd0;
          bits_left_next = 7'd0;
          vshift_next    = 7'd0;
          ones_next      = 3'd0;
          ltime_next     = 64'd0;
          ldelta_next    = 64'd0;
          lvalue_next    = 64'd0;
          lead_next      = 5'd0;
          trail_next     = 6'd0;
          done_cnt_next  = '0;
          chunk_cnt_next = '0;
          stopped_next   = 1'b0;
          vbyte_next     = 8'd0;
          dcode_next     = DOD_64;
        end
      end
    endcase

    // a new result replaces the held one
    if (emit_v) begin
      held_v_next = 1'b1;
      held_next   = emit_r;
    end

    // next byte
    if (take) begin
      busy_next    = 1'b1;
      step_next    = ST_BITS;
      bit_cnt_next = 4'd0;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (take) begin
      cur <= in_item;
    end
  end

  // state update, frozen while a result waits for the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      accum     <= 64'd0;
      bits_left <= 7'd0;
      vshift    <= 7'd0;
      ones      <= 3'd0;
      ltime     <= 64'd0;
      ldelta    <= 64'd0;
      lvalue    <= 64'd0;
      lead      <= 5'd0;
      trail     <= 6'd0;
      done_cnt  <= '0;
      chunk_cnt <= '0;
      stopped   <= 1'b0;
      vbyte     <= 8'd0;
      dcode     <= DOD_64;
      busy      <= 1'b0;
      step      <= ST_OUT;
      bit_cnt   <= 4'd0;
      held_v    <= 1'b0;
    end else if (!stall) begin
      phase     <= phase_next;
      accum     <= accum_next;
      bits_left <= bits_left_next;
      vshift    <= vshift_next;
      ones      <= ones_next;
      ltime     <= ltime_next;
      ldelta    <= ldelta_next;
      lvalue    <= lvalue_next;
      lead      <= lead_next;
      trail     <= trail_next;
      done_cnt  <= done_cnt_next;
      chunk_cnt <= chunk_cnt_next;
      stopped   <= stopped_next;
      vbyte     <= vbyte_next;
      dcode     <= dcode_next;
      busy      <= busy_next;
      step      <= step_next;
      bit_cnt   <= bit_cnt_next;
      held_v    <= held_v_next;
    end
  end

  // held result payload
  always_ff @(posedge clk) begin
    if (!stall) begin
      held <= held_next;
    end
  end

endmodule

### sim/xor_chunk_sample_decoder_tb.sv
// ----------------------------------------------------------------------------
// xor_chunk_sample_decoder_tb
// Self-checking bench for the xor chunk sample decoder. A behavioral decoder
// predicts every result of each accepted chunk byte. Chunks come from a
// directed table and from a chunk encoder with random content, with noise,
// truncated and malformed chunks mixed in, under random stalls on both sides.
// ----------------------------------------------------------------------------
module xor_chunk_sample_decoder_tb;
  import xcsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_index;
  logic [15:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  xor_chunk_sample_decoder DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // register copies
  bit          hdr_mode = 1'b1;
  logic [15:0] fixed_total = '0;

  // behavioral decoder state
  phase_t      dec_phase;
  logic [63:0] acc;
  int          bleft, vshift, pones, dsize, lz, tz;
  logic [63:0] ltime, ldelta, lvalue;
  logic [7:0]  vbyte;
  int unsigned ndone, ncount;
  bit          halted;

  result_t byte_results[$];
  result_t decoded_q[$];

  int errors = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int cycles = 0;
  int bytes_sent = 0;

  function void clear_state();
    dec_phase = PH_IDLE;
    acc = '0; bleft = 0; vshift = 0; pones = 0; dsize = 0;
    ltime = '0; ldelta = '0; lvalue = '0; lz = 0; tz = 0;
    ndone = 0; ncount = 0; halted = 1'b0; vbyte = '0;
  endfunction

  function void emit(logic [1:0] kind, logic [63:0] t, logic [63:0] v);
    result_t r;
    if (byte_results.size() >= 5) return;
    r.last = 1'b0; r.number = ndone[15:0]; r.value = v; r.stamp = t; r.kind = kind;
    byte_results.push_back(r);
  endfunction

  function void fail_chunk();
    emit(KIND_ERROR, '0, '0);
    halted = 1'b1;
  endfunction

  function void begin_field(phase_t p, int n);
    dec_phase = p; acc = '0; bleft = n;
  endfunction

  function void begin_varint();
    dec_phase = PH_VARINT; acc = '0; vshift = 0; vbyte = '0; bleft = 8;
  endfunction

  function bit hit_end();
    if (ltime == TIME_END) begin
      emit(KIND_END, ltime, '0);
      halted = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void sample_out();
    emit(KIND_SAMPLE, ltime, lvalue);
    ndone++;
    if (ndone == ncount) begin
      halted = 1'b1;
      return;
    end
    dec_phase = PH_PREFIX;
    pones = 0;
  endfunction

  function void apply_dod(logic [63:0] dod);
    ldelta += dod;
    ltime += ldelta;
    if (hit_end()) return;
    dec_phase = PH_CTRL1;
  endfunction

  // one complete varint byte: accumulate group, finish on clear top bit
  function void varint_byte();
    logic [63:0] z;
    if (vshift >= 63 && vbyte > 8'd1) begin
      fail_chunk();
      return;
    end
    acc |= {57'd0, vbyte[6:0]} << (vshift & 63);
    if (vbyte[7]) begin
      vshift += 7; vbyte = '0; bleft = 8;
      return;
    end
    z = (acc >> 1) ^ {64{acc[0]}};
    if (ndone == 0) begin
      ltime = z;
      begin_field(PH_VAL64, 64);
    end else begin
      ldelta = z;
      ltime += z;
      if (hit_end()) return;
      dec_phase = PH_CTRL1;
    end
  endfunction

  function void field_done();
    logic [63:0] v;
    int sig;
    v = acc;
    case (dec_phase)
      PH_COUNT: begin
        ncount = v[15:0];
        if (ncount == 0) begin
          halted = 1'b1;
          return;
        end
        begin_varint();
      end
      PH_VAL64: begin
        lvalue = v;
        if (hit_end()) return;
        emit(KIND_SAMPLE, ltime, lvalue);
        ndone = 1;
        if (ndone == ncount) begin
          halted = 1'b1;
          return;
        end
        begin_varint();
      end
      PH_DOD: begin
        if (dsize < 64 && v > (64'd1 << (dsize - 1))) v -= (64'd1 << dsize);
        apply_dod(v);
      end
      PH_LEAD: begin
        lz = v[4:0];
        begin_field(PH_SIG, 6);
      end
      PH_SIG: begin
        sig = v[5:0];
        if (sig == 0) sig = 64;
        if (lz + sig > 64) begin
          fail_chunk();
          return;
        end
        tz = 64 - lz - sig;
        begin_field(PH_MEANING, sig);
      end
      PH_MEANING: begin
        lvalue ^= v << (tz & 63);
        sample_out();
      end
      default: ;
    endcase
  endfunction

  function void take_bit(bit b);
    if (halted) return;
    if (dec_phase == PH_IDLE) begin
      if (hdr_mode) begin
        begin_field(PH_COUNT, 16);
      end else begin
        ncount = fixed_total;
        if (ncount == 0) begin
          halted = 1'b1;
          return;
        end
        begin_varint();
      end
    end
    case (dec_phase)
      PH_VARINT: begin
        vbyte = {vbyte[6:0], b};
        bleft--;
        if (bleft == 0) varint_byte();
      end
      PH_PREFIX: begin
        if (b) begin
          pones++;
          if (pones >= 4) begin
            dsize = 64;
            begin_field(PH_DOD, 64);
          end
        end else if (pones == 0) begin
          apply_dod('0);
        end else begin
          dsize = (pones == 1) ? 14 : (pones == 2) ? 17 : 20;
          begin_field(PH_DOD, dsize);
        end
      end
      PH_CTRL1: begin
        if (b) dec_phase = PH_CTRL2;
        else sample_out();
      end
      PH_CTRL2: begin
        if (b) begin_field(PH_LEAD, 5);
        else begin_field(PH_MEANING, 64 - lz - tz);
      end
      default: begin
        acc = {acc[62:0], b};
        if (bleft > 0) bleft--;
        if (bleft == 0) field_done();
      end
    endcase
  endfunction

  // advance the decoder by one byte; queue its results unless told not to
  function void decode_byte(logic [7:0] d, bit last, bit keep);
    byte_results.delete();
    for (int i = 7; i >= 0; i--) take_bit(d[i]);
    if (last) begin
      if (!halted) emit(KIND_ERROR, '0, '0);
      clear_state();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    if (keep) foreach (byte_results[i]) decoded_q.push_back(byte_results[i]);
  endfunction

  // mismatch report
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("error: %s got %h want %h", what, got, want);
    errors++;
  endtask

  // result side: random stalls and compare
  always @(posedge clk) begin
    result_t w;
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report("unexpected result kind", m_axis_tuser, '0);
      end else begin
        w = decoded_q[0];
        decoded_q.delete(0);
        if (m_axis_tuser !== w.kind) report("result_kind", m_axis_tuser, w.kind);
        if (m_axis_tdata[63:0] !== w.stamp) report("sample_time", m_axis_tdata[63:0], w.stamp);
        if (m_axis_tdata[127:64] !== w.value)
          report("sample_value_bits", m_axis_tdata[127:64], w.value);
        if (m_axis_tdata[143:128] !== w.number)
          report("sample_number", m_axis_tdata[143:128], w.number);
        if (m_axis_tlast !== w.last) report("run_last", m_axis_tlast, w.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("xor_chunk_sample_decoder: mismatch");
      $finish;
    end
  end

  // one byte request, with random gaps before it
  task automatic send_byte(logic [7:0] d, bit last, bit keep);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(d, last, keep);
    bytes_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_config(bit hdr, logic [15:0] total);
    cfg_we <= 1'b1; cfg_index <= REG_COUNT_IN_HEADER; cfg_data <= {15'd0, hdr};
    @(posedge clk);
    cfg_index <= REG_SAMPLE_TOTAL; cfg_data <= total;
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_mode = hdr;
    fixed_total = total;
  endtask

  // chunk encoder
  bit chunk_bits[$];

  function void put_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) chunk_bits.push_back(v[i]);
  endfunction

  function void put_varint(logic [63:0] z);
    logic [6:0] g;
    do begin
      g = z[6:0];
      z = z >> 7;
      put_bits({56'd0, z != 0, g}, 8);
    end while (z != 0);
  endfunction

  function logic [63:0] zigzag(logic [63:0] s);
    return (s << 1) ^ {64{s[63]}};
  endfunction

  function logic [63:0] rand_word();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {{48{1'b0}}, 16'($urandom)};
      2: return -{{48{1'b0}}, 16'($urandom)};
      default: return 64'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_chunk();
    int ns, style, lead, sig, n, elz, etz, nb;
    logic [7:0] d;
    chunk_bits.delete();
    style = $urandom_range(0, 9);
    elz = 0; etz = 0;
    if (hdr_mode) ns = $urandom_range(1, 5);
    else if (fixed_total == 0 || fixed_total > 5) ns = $urandom_range(1, 4);
    else ns = fixed_total;
    if (hdr_mode) put_bits(ns, 16);
    // first sample: varint time, raw value
    put_varint(zigzag(($urandom_range(0, 19) == 0) ? TIME_END : rand_word()));
    put_bits({$urandom, $urandom}, 64);
    for (int i = 1; i < ns; i++) begin
      if (i == 1) begin
        put_varint(zigzag(rand_word()));
      end else begin
        case ($urandom_range(0, 4))
          0: put_bits(0, 1);
          1: begin put_bits(2'b10, 2); put_bits($urandom, 14); end
          2: begin put_bits(3'b110, 3); put_bits($urandom, 17); end
          3: begin put_bits(4'b1110, 4); put_bits($urandom, 20); end
          default: begin put_bits(4'b1111, 4); put_bits({$urandom, $urandom}, 64); end
        endcase
      end
      case ($urandom_range(0, 2))
        0: put_bits(0, 1);
        1: begin
          put_bits(2'b10, 2);
          put_bits({$urandom, $urandom}, 64 - elz - etz);
        end
        default: begin
          lead = $urandom_range(0, 31);
          // malformed chunks may ask for a width past the word
          if (style == 8) sig = $urandom_range(65 - lead, 64);
          else sig = $urandom_range(1, 64 - lead);
          put_bits(2'b11, 2);
          put_bits(lead, 5);
          put_bits(sig & 63, 6);
          if (lead + sig <= 64) begin
            put_bits({$urandom, $urandom}, sig);
            elz = lead; etz = 64 - lead - sig;
          end
        end
      endcase
    end
    // truncated chunk or plain noise
    if (style == 7) begin
      n = $urandom_range(1, chunk_bits.size());
      repeat (n) void'(chunk_bits.pop_back());
    end
    if (style == 9) begin
      chunk_bits.delete();
      put_bits({$urandom, $urandom}, 8 * $urandom_range(1, 6));
    end
    while (chunk_bits.size() % 8 != 0 || chunk_bits.size() == 0)
      chunk_bits.push_back($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) put_bits($urandom, 8 * $urandom_range(1, 2));
    nb = chunk_bits.size() / 8;
    for (int j = 0; j < nb; j++) begin
      for (int k = 0; k < 8; k++) d[7 - k] = chunk_bits[8 * j + k];
      send_byte(d, j == nb - 1, 1'b1);
    end
  endtask

  // directed table
  typedef struct {
    logic [7:0]  data;
    bit          last;
    bit          typed;
    logic [1:0]  kind;
  } stim_row_t;

  stim_row_t rows[$];

  function void add_row(logic [7:0] d, bit last, bit typed, logic [1:0] kind);
    stim_row_t r;
    r.data = d; r.last = last; r.typed = typed; r.kind = kind;
    rows.push_back(r);
  endfunction

  initial begin
    result_t tr;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    clear_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header cut short
    add_row(8'h00, 1'b1, 1'b1, KIND_ERROR);
    // full-scale count, chunk ends before the first time field
    add_row(8'hff, 1'b0, 1'b0, KIND_SAMPLE);
    add_row(8'hff, 1'b1, 1'b1, KIND_ERROR);
    // zero count gives nothing
    add_row(8'h00, 1'b0, 1'b0, KIND_SAMPLE);
    add_row(8'h00, 1'b1, 1'b0, KIND_SAMPLE);
    // varint overflowing in its tenth byte
    add_row(8'h00, 1'b0, 1'b0, KIND_SAMPLE);
    add_row(8'h01, 1'b0, 1'b0, KIND_SAMPLE);
    repeat (9) add_row(8'hff, 1'b0, 1'b0, KIND_SAMPLE);
    add_row(8'h02, 1'b1, 1'b1, KIND_ERROR);

    src_idle = 26; snk_idle = 56;
    foreach (rows[i]) begin
      send_byte(rows[i].data, rows[i].last, !rows[i].typed);
      if (rows[i].typed) begin
        tr.last = 1'b1; tr.number = '0; tr.value = '0; tr.stamp = '0;
        tr.kind = rows[i].kind;
        decoded_q.push_back(tr);
      end
    end

    // random part, one register setting per phase
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: set_config(1'b1, 16'd0);
        1: set_config(1'b0, 16'd3);
        2: set_config(1'b0, 16'd0);
        3: set_config(1'b0, 16'hffff);
        4: set_config(1'b0, 16'($urandom_range(1, 5)));
        default: set_config(1'b1, 16'($urandom));
      endcase
      src_idle = (p < 2) ? 26 : (p < 4) ? 56 : 0;
      snk_idle = (p < 2) ? 56 : (p < 4) ? 26 : 0;
      while (bytes_sent < 17 + 56 * (p + 1)) begin
        send_chunk();
        // hold the sender until the output side has caught up
        if (p == 0 && $urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    if (errors == 0) $display("xor_chunk_sample_decoder: match");
    else $display("xor_chunk_sample_decoder: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/core/xcsd_pkg.sv
rtl/core/xcsd_fifo.sv
rtl/core/xcsd_back.sv
rtl/core/xor_chunk_sample_decoder.sv
sim/xor_chunk_sample_decoder_tb.sv
